[rtl/core/ppqn_pkg.sv]
package ppqn_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INCREMENT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NCO_SCALE_QUARTERS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_ADJUST       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_BANDWIDTH     = 3'd3;
    localparam int CFG_DATA_BITS = 32;

    localparam int DEF_PHASE_BITS  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // CORDIC
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = 5;
    localparam int ZW           = 34;
    localparam logic [31:0] CORDIC_X0 = 32'd652032874;

    // Loop gains, 2.666 and 3.555 in Q.16
    localparam logic [MUL_B_W-1:0] GAIN_P = 26'd174719;
    localparam logic [MUL_B_W-1:0] GAIN_I = 26'd232980;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             vector_mode;
        logic [ITER_W-1:0] iter;
    } cordic_ctl_t;

    // Arctangent of 2^-i in 2^-32 turn
    function automatic logic [ZW-1:0] cordic_angle(input logic [ITER_W-1:0] i);
        logic [ZW-1:0] a;
        begin
            a = '0;
            unique case (i)
                5'd0:  a = 34'd536870912;
                5'd1:  a = 34'd316933406;
                5'd2:  a = 34'd167458907;
                5'd3:  a = 34'd85004756;
                5'd4:  a = 34'd42667331;
                5'd5:  a = 34'd21354465;
                5'd6:  a = 34'd10679838;
                5'd7:  a = 34'd5340245;
                5'd8:  a = 34'd2670163;
                5'd9:  a = 34'd1335087;
                5'd10: a = 34'd667544;
                5'd11: a = 34'd333772;
                5'd12: a = 34'd166886;
                5'd13: a = 34'd83443;
                5'd14: a = 34'd41722;
                5'd15: a = 34'd20861;
                5'd16: a = 34'd10430;
                5'd17: a = 34'd5215;
                5'd18: a = 34'd2608;
                5'd19: a = 34'd1304;
                5'd20: a = 34'd652;
                5'd21: a = 34'd326;
                5'd22: a = 34'd163;
                5'd23: a = 34'd81;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

[rtl/core/ppqn_mul.sv]
module ppqn_mul (
    input  logic                                clk,
    input  logic signed [ppqn_pkg::MUL_A_W-1:0] a,
    input  logic signed [ppqn_pkg::MUL_B_W-1:0] b,
    output logic signed [ppqn_pkg::MUL_P_W-1:0] p
);
    import ppqn_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] p_next;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[rtl/core/ppqn_cordic.sv]
module ppqn_cordic #(
    parameter int XW = 35
) (
    input  logic                         clk,
    input  ppqn_pkg::cordic_ctl_t        ctl,
    input  logic signed [XW-1:0]         x_in,
    input  logic signed [XW-1:0]         y_in,
    input  logic signed [ppqn_pkg::ZW-1:0] z_in,
    output logic signed [XW-1:0]         x,
    output logic signed [XW-1:0]         y,
    output logic signed [ppqn_pkg::ZW-1:0] z
);
    import ppqn_pkg::*;

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    logic                 neg;

    assign xs  = y_reg >>> ctl.iter;
    assign ys  = x_reg >>> ctl.iter;
    assign ang = signed'(cordic_angle(ctl.iter));
    // vectoring drives y to zero, rotation drives z to zero
    assign neg = ctl.vector_mode ? y_reg[XW-1] : !z_reg[ZW-1];

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl.load)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (ctl.step)
        begin
            if (neg)
            begin
                x_next = x_reg - xs;
                y_next = y_reg + ys;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + xs;
                y_next = y_reg - ys;
                z_next = z_reg + ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

endmodule

[rtl/core/pilot_pll_quadrature_nco.sv]
// Pilot PLL with quadrature NCO. Each accepted sample request returns one
// result: the cosine and sine (Q1.15) of the scaled NCO phase computed on the
// previous request, so the output lags the loop by one sample. The sample is
// mixed with the stored feedback phasor, a vectoring CORDIC gives the phase
// error, a PI loop filter steers the phase estimate, and two rotation CORDIC
// passes produce the new feedback phasor and the output phasor. All of this
// runs through one CORDIC micro-rotation unit and one 35x26 multiplier under
// a sequencer, so an item occupies the block through three 24-step CORDIC
// passes on the shared unit; when the mixed product is zero the vectoring
// pass is skipped and only the two rotation passes run. in_stall stays high
// while an item is in the block. The result is held in an output register,
// so the next sample may be accepted while it still waits, as long as the
// register is free or being taken. Configuration writes go through
// cfg_we/cfg_index/cfg_data and must be issued only while the block is idle;
// writes past index 3 are dropped.
module pilot_pll_quadrature_nco #(
    parameter int PHASE_BITS  = ppqn_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = ppqn_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [15:0]                    nco_cos,
    output logic signed [15:0]                    nco_sin,
    input  logic                                  cfg_we,
    input  logic [ppqn_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ppqn_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import ppqn_pkg::*;

    localparam int PW   = PHASE_BITS + 2;        // phase modulo four turns
    localparam int XW   = (SAMPLE_BITS + 19 > 34) ? SAMPLE_BITS + 19 : 34;
    localparam int SH   = 56 - PHASE_BITS;       // loop filter product shift
    localparam int RW   = MUL_P_W + 1;           // rounded product width
    localparam int EW   = 25;                    // phase error, 2^-24 turn

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MULX    = 4'd1;
    localparam logic [3:0] S_MULY    = 4'd2;
    localparam logic [3:0] S_VLOAD   = 4'd3;
    localparam logic [3:0] S_VEC     = 4'd4;
    localparam logic [3:0] S_VDONE   = 4'd5;
    localparam logic [3:0] S_G1      = 4'd6;
    localparam logic [3:0] S_G2      = 4'd7;
    localparam logic [3:0] S_G3      = 4'd8;
    localparam logic [3:0] S_G4      = 4'd9;
    localparam logic [3:0] S_G5      = 4'd10;
    localparam logic [3:0] S_G6      = 4'd11;
    localparam logic [3:0] S_ARG     = 4'd12;
    localparam logic [3:0] S_ROT     = 4'd13;
    localparam logic [3:0] S_ROTDONE = 4'd14;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Round half away from zero by SH bits
    function automatic logic signed [RW-1:0] round_sh(input logic signed [MUL_P_W-1:0] v);
        logic [RW-1:0] mag;
        begin
            mag = v[MUL_P_W-1] ? RW'(-(RW'(v))) : RW'(v);
            mag = (mag + (RW'(1) << (SH - 1))) >> SH;
            return v[MUL_P_W-1] ? signed'(-mag) : signed'(mag);
        end
    endfunction

    // Round half away from zero by 15 bits, saturate to 16-bit range
    function automatic logic signed [16:0] to_q15(input logic signed [XW-1:0] v);
        logic [XW-1:0]        mag;
        logic signed [XW-1:0] r;
        begin
            mag = v[XW-1] ? XW'(-v) : XW'(v);
            mag = (mag + XW'(16384)) >> 15;
            r   = v[XW-1] ? signed'(-mag) : signed'(mag);
            if (r > XW'(32767))
                return 17'sd32767;
            else if (r < -XW'(32768))
                return -17'sd32768;
            else
                return 17'(r);
        end
    endfunction

    function automatic logic signed [15:0] clamp_pos(input logic signed [16:0] v);
        return (v > 17'sd32767) ? 16'sd32767 : 16'(v);
    endfunction

    // Angle in 2^-32 turn from a phase in 2^-PHASE_BITS turn
    function automatic logic [31:0] to32(input logic [PW-1:0] p);
        logic [PHASE_BITS+31:0] t;
        begin
            t = {p[PHASE_BITS-1:0], 32'b0} >> PHASE_BITS;
            return t[31:0];
        end
    endfunction

    function automatic logic [PW-1:0] from32(input logic [31:0] v);
        logic [PHASE_BITS+31:0] t;
        begin
            t = {v, PHASE_BITS'(0)} >> 32;
            return PW'(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]              state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    pass_reg, pass_next;
    logic [1:0]              quad_reg, quad_next;

    logic [30:0]             inc_reg, inc_next;
    logic [4:0]              scale_reg, scale_next;
    logic [31:0]             adj_reg, adj_next;
    logic [15:0]             bw_reg, bw_next;

    logic [PW-1:0]           nom_reg, nom_next;
    logic [PW-1:0]           est_reg, est_next;
    logic signed [31:0]      integ_reg, integ_next;
    logic signed [15:0]      fb_cos_reg, fb_cos_next, fb_sin_reg, fb_sin_next;
    logic signed [15:0]      last_cos_reg, last_cos_next, last_sin_reg, last_sin_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [15:0]      out_cos_reg, out_cos_next, out_sin_reg, out_sin_next;

    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic signed [MUL_P_W-1:0]     px_reg, px_next;
    logic signed [EW-1:0]          err_reg, err_next;
    logic [MUL_A_W-1:0]            ki_reg, ki_next, kp_reg, kp_next;
    logic [PW-1:0]                 arg_reg, arg_next;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    ppqn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    cordic_ctl_t           cctl;
    logic signed [XW-1:0]  cx_in, cy_in, cx, cy;
    logic signed [ZW-1:0]  cz_in, cz;

    ppqn_cordic #(.XW(XW)) u_cordic (
        .clk  (clk),
        .ctl  (cctl),
        .x_in (cx_in),
        .y_in (cy_in),
        .z_in (cz_in),
        .x    (cx),
        .y    (cy),
        .z    (cz)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                    in_accept, out_take;
    logic signed [XW-1:0]    vx, vy;
    logic signed [31:0]      zw;
    logic [PW-1:0]           arg_sum;
    logic [PW+4:0]           scaled;
    logic [PHASE_BITS-1:0]   theta;
    logic [31:0]             rot_a;
    logic [1:0]              rot_q;
    logic [31:0]             rot_z;
    logic signed [16:0]      qx, qy, mc, ms;
    logic signed [RW-1:0]    rterm;
    logic signed [RW:0]      isum;
    logic [31:0]             zmag;

    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign vx = XW'(px_reg);
    assign vy = -XW'(mul_p);

    assign arg_sum = nom_reg + est_reg;
    assign scaled  = (PW+5)'(arg_reg) * (PW+5)'(scale_reg);
    assign theta   = PHASE_BITS'(scaled[PW-1:2]) + PHASE_BITS'(from32(adj_reg));

    // Pick the phase for the rotation pass about to start
    always_comb
    begin
        if (state_reg == S_ARG)
            rot_a = to32(arg_sum);
        else
            rot_a = to32(PW'(theta));
    end
    assign rot_q = 2'((rot_a + 32'h2000_0000) >> 30);
    assign rot_z = rot_a - {rot_q, 30'b0};

    assign zw   = cz[31:0];
    assign zmag = zw[31] ? 32'(-zw) : 32'(zw);
    assign rterm = round_sh(mul_p);
    assign isum  = (RW+1)'(integ_reg) + (RW+1)'(rterm);

    assign qx = to_q15(cx);
    assign qy = to_q15(cy);

    // Fold the quadrant back in
    always_comb
    begin
        mc = qx;
        ms = qy;
        unique case (quad_reg)
            2'd0:
            begin
                mc = qx;
                ms = qy;
            end
            2'd1:
            begin
                mc = -qy;
                ms = qx;
            end
            2'd2:
            begin
                mc = -qx;
                ms = -qy;
            end
            2'd3:
            begin
                mc = qy;
                ms = -qx;
            end
            default:
            begin
                mc = qx;
                ms = qy;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        pass_next     = pass_reg;
        quad_next     = quad_reg;
        inc_next      = inc_reg;
        scale_next    = scale_reg;
        adj_next      = adj_reg;
        bw_next       = bw_reg;
        nom_next      = nom_reg;
        est_next      = est_reg;
        integ_next    = integ_reg;
        fb_cos_next   = fb_cos_reg;
        fb_sin_next   = fb_sin_reg;
        last_cos_next = last_cos_reg;
        last_sin_next = last_sin_reg;
        out_cos_next  = out_cos_reg;
        out_sin_next  = out_sin_reg;
        smp_next      = smp_reg;
        px_next       = px_reg;
        err_next      = err_reg;
        ki_next       = ki_reg;
        kp_next       = kp_reg;
        arg_next      = arg_reg;

        mul_a = '0;
        mul_b = '0;
        cctl  = '0;
        cx_in = '0;
        cy_in = '0;
        cz_in = '0;

        // Output register: drop when taken, reload on each accepted request
        out_valid_next = out_valid_reg && !out_take;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_INCREMENT:    inc_next   = cfg_data[30:0];
                CFG_NCO_SCALE_QUARTERS: scale_next = cfg_data[4:0];
                CFG_PHASE_ADJUST:       adj_next   = cfg_data;
                CFG_LOOP_BANDWIDTH:     bw_next    = cfg_data[15:0];
                default:                ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    smp_next       = sample;
                    out_valid_next = 1'b1;
                    out_cos_next   = last_cos_reg;
                    out_sin_next   = last_sin_reg;
                    state_next     = S_MULX;
                end
            end
            S_MULX:
            begin
                // Mix the sample with the conjugate feedback phasor
                mul_a      = MUL_A_W'(fb_cos_reg);
                mul_b      = MUL_B_W'(smp_reg);
                state_next = S_MULY;
            end
            S_MULY:
            begin
                mul_a      = MUL_A_W'(fb_sin_reg);
                mul_b      = MUL_B_W'(smp_reg);
                px_next    = mul_p;
                state_next = S_VLOAD;
            end
            S_VLOAD:
            begin
                if (px_reg == '0 && mul_p == '0)
                begin
                    err_next   = '0;
                    state_next = S_G1;
                end
                else
                begin
                    cctl.load        = 1'b1;
                    cctl.vector_mode = 1'b1;
                    // Pre-rotate by a half turn off the left half plane
                    if (px_reg < 0)
                    begin
                        cx_in = -vx;
                        cy_in = -vy;
                        cz_in = ZW'(33'h0_8000_0000);
                    end
                    else
                    begin
                        cx_in = vx;
                        cy_in = vy;
                        cz_in = '0;
                    end
                    iter_next  = '0;
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                cctl.step        = 1'b1;
                cctl.vector_mode = 1'b1;
                cctl.iter        = iter_reg;
                iter_next        = iter_reg + ITER_W'(1);
                if (iter_reg == LAST_ITER)
                    state_next = S_VDONE;
            end
            S_VDONE:
            begin
                // Wrap to a half turn either way, round to 2^-24 turn
                if (zw[31])
                    err_next = -EW'((zmag + 32'd128) >> 8);
                else
                    err_next = EW'((zmag + 32'd128) >> 8);
                state_next = S_G1;
            end
            S_G1:
            begin
                mul_a      = MUL_A_W'(bw_reg);
                mul_b      = MUL_B_W'(bw_reg);
                state_next = S_G2;
            end
            S_G2:
            begin
                mul_a      = MUL_A_W'(mul_p[31:0]);
                mul_b      = GAIN_I;
                state_next = S_G3;
            end
            S_G3:
            begin
                ki_next    = MUL_A_W'((mul_p + MUL_P_W'(32768)) >>> 16);
                mul_a      = MUL_A_W'(bw_reg);
                mul_b      = GAIN_P;
                state_next = S_G4;
            end
            S_G4:
            begin
                kp_next    = MUL_A_W'(mul_p);
                mul_a      = signed'(ki_reg);
                mul_b      = MUL_B_W'(err_reg);
                state_next = S_G5;
            end
            S_G5:
            begin
                // Integral path with saturation to 32 bits
                if (isum > (RW+1)'(32'sh7FFF_FFFF))
                    integ_next = 32'sh7FFF_FFFF;
                else if (isum < -(RW+1)'(33'sh0_8000_0000))
                    integ_next = -32'sh7FFF_FFFF - 32'sd1;
                else
                    integ_next = 32'(isum);
                mul_a      = signed'(kp_reg);
                mul_b      = MUL_B_W'(err_reg);
                state_next = S_G6;
            end
            S_G6:
            begin
                est_next   = est_reg + PW'(rterm) + PW'(integ_reg);
                nom_next   = nom_reg + from32({1'b0, inc_reg});
                state_next = S_ARG;
            end
            S_ARG:
            begin
                arg_next         = arg_sum;
                cctl.load        = 1'b1;
                cx_in            = XW'(signed'({1'b0, CORDIC_X0}));
                cy_in            = '0;
                cz_in            = ZW'(signed'(rot_z));
                quad_next        = rot_q;
                pass_next        = 1'b0;
                iter_next        = '0;
                state_next       = S_ROT;
            end
            S_ROT:
            begin
                cctl.step = 1'b1;
                cctl.iter = iter_reg;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == LAST_ITER)
                    state_next = S_ROTDONE;
            end
            S_ROTDONE:
            begin
                if (!pass_reg)
                begin
                    // Hold the new feedback phasor, start the output pass
                    fb_cos_next = clamp_pos(mc);
                    fb_sin_next = clamp_pos(ms);
                    cctl.load   = 1'b1;
                    cx_in       = XW'(signed'({1'b0, CORDIC_X0}));
                    cy_in       = '0;
                    cz_in       = ZW'(signed'(rot_z));
                    quad_next   = rot_q;
                    pass_next   = 1'b1;
                    iter_next   = '0;
                    state_next  = S_ROT;
                end
                else
                begin
                    last_cos_next = clamp_pos(mc);
                    last_sin_next = clamp_pos(ms);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            pass_reg      <= 1'b0;
            quad_reg      <= '0;
            inc_reg       <= '0;
            scale_reg     <= 5'd4;
            adj_reg       <= '0;
            bw_reg        <= 16'd655;
            nom_reg       <= '0;
            est_reg       <= '0;
            integ_reg     <= '0;
            fb_cos_reg    <= 16'sd32767;
            fb_sin_reg    <= '0;
            last_cos_reg  <= 16'sd32767;
            last_sin_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            pass_reg      <= pass_next;
            quad_reg      <= quad_next;
            inc_reg       <= inc_next;
            scale_reg     <= scale_next;
            adj_reg       <= adj_next;
            bw_reg        <= bw_next;
            nom_reg       <= nom_next;
            est_reg       <= est_next;
            integ_reg     <= integ_next;
            fb_cos_reg    <= fb_cos_next;
            fb_sin_reg    <= fb_sin_next;
            last_cos_reg  <= last_cos_next;
            last_sin_reg  <= last_sin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cos_reg <= out_cos_next;
        out_sin_reg <= out_sin_next;
        smp_reg     <= smp_next;
        px_reg      <= px_next;
        err_reg     <= err_next;
        ki_reg      <= ki_next;
        kp_reg      <= kp_next;
        arg_reg     <= arg_next;
    end

    assign out_valid = out_valid_reg;
    assign nco_cos   = out_cos_reg;
    assign nco_sin   = out_sin_reg;

endmodule
